[design/loco_slot_table_manager_core_defines.svh]
// Assertion macros used by the asserting file.
`ifndef LOCO_SLOT_TABLE_MANAGER_CORE_DEFINES_SVH
`define LOCO_SLOT_TABLE_MANAGER_CORE_DEFINES_SVH
`define LSTM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define LSTM_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[design/lstm_pkg.sv]
`default_nettype none
package lstm_pkg;
  typedef enum logic [3:0] {
    OP_PWR_ON = 4'd0, OP_PWR_OFF = 4'd1, OP_ESTOP = 4'd2, OP_REQ = 4'd3,
    OP_MOVE = 4'd4, OP_STAT = 4'd5, OP_SPEED = 4'd6, OP_DIRF = 4'd7,
    OP_SOUND = 4'd8, OP_PROG = 4'd9, OP_NONE = 4'd15
  } op_t;
  localparam logic [2:0] K_POWER = 3'd0;
  localparam logic [2:0] K_SLOT = 3'd1;
  localparam logic [2:0] K_NOSLOT = 3'd2;
  localparam logic [2:0] K_NOTIMP = 3'd3;
  localparam logic [2:0] K_CVRD = 3'd4;
  localparam logic [2:0] K_CVWR = 3'd5;
  localparam logic [2:0] K_THR = 3'd6;
  localparam logic [2:0] PK_NONE = 3'd7;
  localparam logic [6:0] PROG_SLOT = 7'h7C;
  localparam logic [6:0] STAT_FREE = 7'h03;
  localparam logic [6:0] STAT_IDLE = 7'h13;
  localparam logic [6:0] ACK_OK = 7'h01;
  localparam logic [6:0] ACK_UNSUP = 7'h7F;
  typedef struct packed {
    op_t        op;
    logic [6:0] sn;
    logic       sn_ok;
    logic       move_ok;
    logic [6:0] alo;
    logic [6:0] ahi;
    logic [6:0] val;
    logic [2:0] pkind;
    logic [10:0] cvn;
    logic [7:0] cvv;
  } cmd_t;
endpackage
`default_nettype wire

[design/lstm_front.sv]
`default_nettype none
module lstm_front #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [3:0]     op,
  input  wire logic [6:0]     slot_num,
  input  wire logic [6:0]     dest_slot,
  input  wire logic [6:0]     addr_lo,
  input  wire logic [6:0]     addr_hi,
  input  wire logic [6:0]     value,
  input  wire logic [6:0]     prog_cmd,
  input  wire logic [6:0]     cv_high,
  input  wire logic [6:0]     cv_low,
  input  wire logic [6:0]     data_low,
  output logic                q_valid,
  input  wire logic           q_ready,
  output lstm_pkg::cmd_t      q_cmd
);
  localparam logic [6:0] NS = 7'(NUM_SLOTS);
  lstm_pkg::cmd_t c;
  lstm_pkg::cmd_t mem [2];
  logic [1:0] wp, rp;
  logic full;
  always_comb begin
    c = '0;
    c.op = lstm_pkg::op_t'(op);
    if (op > 4'd9) c.op = lstm_pkg::OP_NONE;
    c.sn = slot_num;
    c.sn_ok = slot_num < NS;
    c.move_ok = (slot_num == dest_slot) && (slot_num < NS) && (slot_num != 7'd0);
    c.alo = addr_lo;
    c.ahi = addr_hi;
    c.val = value;
    c.pkind = lstm_pkg::PK_NONE;
    if (slot_num == lstm_pkg::PROG_SLOT && prog_cmd != 7'd0) begin
      if (!prog_cmd[5] || (prog_cmd[6] && prog_cmd[2])) c.pkind = lstm_pkg::K_NOTIMP;
      else if (!prog_cmd[2]) c.pkind = prog_cmd[6] ? lstm_pkg::K_CVWR : lstm_pkg::K_CVRD;
    end
    c.cvn = 11'({cv_high[5:4], cv_high[0], cv_low}) + 11'd1;
    c.cvv = {cv_high[1], data_low};
  end
  assign full = (wp[1] != rp[1]) && (wp[0] == rp[0]);
  assign in_ready = !full;
  assign q_valid = wp != rp;
  assign q_cmd = mem[rp[0]];
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp[0]] <= c;
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (in_valid && in_ready) wp <= wp + 2'd1;
      if (q_valid && q_ready) rp <= rp + 2'd1;
    end
  end
endmodule
`default_nettype wire

[design/lstm_back.sv]
`default_nettype none
module lstm_back #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire lstm_pkg::cmd_t q_cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          resp_kind,
  output logic [6:0]          slot_index,
  output logic [6:0]          slot_status,
  output logic [13:0]         loco_address,
  output logic [6:0]          speed,
  output logic [6:0]          dir_func,
  output logic [7:0]          function_byte,
  output logic [1:0]          power_state,
  output logic [10:0]         cv_number,
  output logic [7:0]          cv_value,
  output logic [6:0]          ack_code
);
  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic [SW:0] NSL = (SW + 1)'(NUM_SLOTS);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_t;
  state_t state;
  logic [6:0] st [NUM_SLOTS];
  logic [6:0] al [NUM_SLOTS];
  logic [6:0] ah [NUM_SLOTS];
  logic [6:0] sp [NUM_SLOTS];
  logic [6:0] df [NUM_SLOTS];
  logic [3:0] snd [NUM_SLOTS];
  logic [1:0] pwr;
  lstm_pkg::cmd_t cur;
  logic [SW:0] idx, freeslot;
  logic [SW-1:0] s, si;
  logic [2:0] rk;
  logic [7:0] fb;
  logic [6:0] ack;
  logic       slotres;
  logic       has_res;
  assign s = cur.sn[SW-1:0];
  assign si = idx[SW-1:0];
  assign q_ready = (state == S_IDLE) && !out_valid;
  always_comb begin
    rk = lstm_pkg::K_POWER;
    fb = 8'h80 | {3'b0, df[s][4:0]};
    ack = '0;
    slotres = 1'b0;
    has_res = 1'b0;
    unique case (cur.op)
      lstm_pkg::OP_PWR_ON, lstm_pkg::OP_PWR_OFF, lstm_pkg::OP_ESTOP: has_res = 1'b1;
      lstm_pkg::OP_REQ: begin
        has_res = 1'b1;
        rk = (idx == NSL) ? lstm_pkg::K_NOSLOT : lstm_pkg::K_SLOT;
        slotres = idx != NSL;
      end
      lstm_pkg::OP_MOVE: begin
        has_res = 1'b1;
        rk = lstm_pkg::K_NOSLOT;
        if (cur.move_ok) begin
          rk = lstm_pkg::K_THR;
          slotres = 1'b1;
        end
      end
      lstm_pkg::OP_SPEED, lstm_pkg::OP_DIRF, lstm_pkg::OP_SOUND: if (cur.sn_ok) begin
        has_res = 1'b1;
        rk = lstm_pkg::K_THR;
        slotres = 1'b1;
        if (cur.op == lstm_pkg::OP_DIRF) fb = 8'h80 | {3'b0, cur.val[4:0]};
        if (cur.op == lstm_pkg::OP_SOUND) fb = 8'hB0 | {4'b0, cur.val[3:0]};
      end
      lstm_pkg::OP_PROG: if (cur.pkind != lstm_pkg::PK_NONE) begin
        has_res = 1'b1;
        rk = cur.pkind;
        if (cur.pkind == lstm_pkg::K_NOTIMP) ack = lstm_pkg::ACK_UNSUP;
        else ack = lstm_pkg::ACK_OK;
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pwr <= 2'd1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st[i] <= lstm_pkg::STAT_FREE;
        al[i] <= '0; ah[i] <= '0; sp[i] <= '0; df[i] <= '0; snd[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid && q_ready) begin
          cur <= q_cmd;
          idx <= (SW + 1)'(1);
          freeslot <= NSL;
          state <= (q_cmd.op == lstm_pkg::OP_REQ) ? S_SCAN : S_RESP;
          unique case (q_cmd.op)
            lstm_pkg::OP_PWR_ON: pwr <= 2'd1;
            lstm_pkg::OP_PWR_OFF: pwr <= 2'd0;
            lstm_pkg::OP_ESTOP: pwr <= 2'd2;
            default: ;
          endcase
        end
        S_SCAN: begin
          if (idx == NSL) begin
            if (freeslot == NSL) idx <= NSL;
            else begin
              idx <= freeslot;
              st[freeslot[SW-1:0]] <= lstm_pkg::STAT_IDLE;
              al[freeslot[SW-1:0]] <= cur.alo;
              ah[freeslot[SW-1:0]] <= cur.ahi;
              sp[freeslot[SW-1:0]] <= '0;
              df[freeslot[SW-1:0]] <= 7'h10;
              snd[freeslot[SW-1:0]] <= '0;
            end
            state <= S_RESP;
          end else if (st[si][5:4] == 2'b00) begin
            if (freeslot == NSL) freeslot <= idx;
            idx <= idx + (SW + 1)'(1);
          end else if (al[si] == cur.alo && ah[si] == cur.ahi) begin
            state <= S_RESP;
          end else idx <= idx + (SW + 1)'(1);
        end
        S_RESP: begin
          state <= S_IDLE;
          out_valid <= has_res;
          if (cur.op == lstm_pkg::OP_MOVE && cur.move_ok) st[s] <= st[s] | 7'h30;
          if (cur.sn_ok) begin
            if (cur.op == lstm_pkg::OP_STAT) st[s] <= cur.val;
            if (cur.op == lstm_pkg::OP_SPEED) sp[s] <= cur.val;
            if (cur.op == lstm_pkg::OP_DIRF) df[s] <= cur.val;
            if (cur.op == lstm_pkg::OP_SOUND) snd[s] <= cur.val[3:0];
          end
          resp_kind <= rk;
          power_state <= pwr;
          ack_code <= ack;
          cv_number <= (rk == lstm_pkg::K_CVRD || rk == lstm_pkg::K_CVWR) ? cur.cvn : '0;
          cv_value <= (rk == lstm_pkg::K_CVRD || rk == lstm_pkg::K_CVWR) ? cur.cvv : '0;
          slot_index <= '0; slot_status <= '0; loco_address <= '0;
          speed <= '0; dir_func <= '0; function_byte <= '0;
          if (slotres && cur.op == lstm_pkg::OP_REQ) begin
            slot_index <= 7'(idx);
            slot_status <= st[si];
            loco_address <= {ah[si], al[si]};
            speed <= sp[si];
            dir_func <= df[si];
          end else if (slotres) begin
            slot_index <= cur.sn;
            slot_status <= (cur.op == lstm_pkg::OP_MOVE) ? (st[s] | 7'h30) : st[s];
            loco_address <= {ah[s], al[s]};
            speed <= (cur.op == lstm_pkg::OP_SPEED) ? cur.val : sp[s];
            dir_func <= (cur.op == lstm_pkg::OP_DIRF) ? cur.val : df[s];
            function_byte <= fb;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/loco_slot_table_manager_core.sv]
// Locomotive slot table manager.
// Input channel in_valid/in_ready carries one decoded bus command per transfer;
// output channel out_valid/out_ready carries zero or one response per command.
// A two-entry queue separates the command decoder from the slot engine.
// Most commands pass from the queue through the engine's idle and response
// states, and the response is registered in the response state.
// A loco request walks slots 1..NUM_SLOTS-1, one per cycle, plus a final
// step to claim a free slot, stopping early on a matching address; that
// scan sets the worst-case rate. Otherwise the engine takes a new command
// only once the last has left its response state and its response is taken.
// Commands without a response (status, throttle commands on an out-of-range
// slot, ignored program tasks, unknown codes) give none; status updates the table.
// When the receiver stalls, the response is held and the engine waits;
// the queue keeps taking up to two commands meanwhile.
// Reset marks every slot free in 128-step mode with zero data and turns
// track power on.
`default_nettype none
`include "loco_slot_table_manager_core_defines.svh"
module loco_slot_table_manager_core #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  op,
  input  wire logic [6:0]  slot_num,
  input  wire logic [6:0]  dest_slot,
  input  wire logic [6:0]  addr_lo,
  input  wire logic [6:0]  addr_hi,
  input  wire logic [6:0]  value,
  input  wire logic [6:0]  prog_cmd,
  input  wire logic [6:0]  cv_high,
  input  wire logic [6:0]  cv_low,
  input  wire logic [6:0]  data_low,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       resp_kind,
  output logic [6:0]       slot_index,
  output logic [6:0]       slot_status,
  output logic [13:0]      loco_address,
  output logic [6:0]       speed,
  output logic [6:0]       dir_func,
  output logic [7:0]       function_byte,
  output logic [1:0]       power_state,
  output logic [10:0]      cv_number,
  output logic [7:0]       cv_value,
  output logic [6:0]       ack_code
);
  logic q_valid, q_ready;
  lstm_pkg::cmd_t q_cmd;
  lstm_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .slot_num, .dest_slot, .addr_lo,
    .addr_hi, .value, .prog_cmd, .cv_high, .cv_low, .data_low,
    .q_valid, .q_ready, .q_cmd
  );
  lstm_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready,
    .resp_kind, .slot_index, .slot_status, .loco_address, .speed, .dir_func,
    .function_byte, .power_state, .cv_number, .cv_value, .ack_code
  );
  `LSTM_ASSERT_IMP(a_no_take_while_out, clk, rst, out_valid, !q_ready)
  `LSTM_ASSERT_IMP(a_power_range, clk, rst, out_valid, power_state != 2'd3)
  `LSTM_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(resp_kind))
endmodule
`default_nettype wire

[bench/loco_slot_table_manager_core_test.sv]
`timescale 1ns / 100ps
`default_nettype none

module loco_slot_table_manager_core_test;

  localparam int NSLOTS = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [3:0] op;
    logic [6:0] sn;
    logic [6:0] dn;
    logic [6:0] alo;
    logic [6:0] ahi;
    logic [6:0] val;
    logic [6:0] pcmd;
    logic [6:0] cvh;
    logic [6:0] cvl;
    logic [6:0] dlo;
  } command_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] idx;
    logic [6:0] stat;
    logic [13:0] addr;
    logic [6:0] spd;
    logic [6:0] df;
    logic [7:0] fbyte;
    logic [1:0] pwr;
    logic [10:0] cvn;
    logic [7:0] cvv;
    logic [6:0] ack;
  } response_t;

  class slot_table_scoreboard;
    logic [6:0] stat_q[NSLOTS];
    logic [6:0] alo_q[NSLOTS];
    logic [6:0] ahi_q[NSLOTS];
    logic [6:0] spd_q[NSLOTS];
    logic [6:0] df_q[NSLOTS];
    logic [3:0] snd_q[NSLOTS];
    logic [1:0] pwr;
    response_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        stat_q[i] = lstm_pkg::STAT_FREE;
        alo_q[i] = '0;
        ahi_q[i] = '0;
        spd_q[i] = '0;
        df_q[i] = '0;
        snd_q[i] = '0;
      end
      pwr = 2'd1;
      errors = 0;
    endfunction

    function response_t slot_view(int s, logic [2:0] kind, logic [7:0] fb);
      response_t r;
      r = '0;
      r.kind = kind;
      r.idx = s[6:0];
      r.stat = stat_q[s];
      r.addr = {7'd0, alo_q[s]} + {ahi_q[s], 7'd0};
      r.spd = spd_q[s];
      r.df = df_q[s];
      r.fbyte = fb;
      return r;
    endfunction

    function void note_command(command_t c);
      response_t r;
      int found;
      int free_slot;
      bit has;
      bit wr;
      bit ops;
      r = '0;
      has = 1'b1;
      case (c.op)
        lstm_pkg::OP_PWR_ON, lstm_pkg::OP_PWR_OFF, lstm_pkg::OP_ESTOP: begin
          pwr = (c.op == lstm_pkg::OP_PWR_ON) ? 2'd1 :
                (c.op == lstm_pkg::OP_PWR_OFF) ? 2'd0 : 2'd2;
          r.kind = lstm_pkg::K_POWER;
        end
        lstm_pkg::OP_REQ: begin
          found = NSLOTS;
          free_slot = NSLOTS;
          for (int i = 1; i < NSLOTS; i++) begin
            if (found == NSLOTS) begin
              if (stat_q[i][5:4] == 2'b00) begin
                if (free_slot == NSLOTS) free_slot = i;
              end else if (alo_q[i] == c.alo && ahi_q[i] == c.ahi) begin
                found = i;
              end
            end
          end
          if (found == NSLOTS && free_slot == NSLOTS) begin
            r.kind = lstm_pkg::K_NOSLOT;
          end else begin
            if (found == NSLOTS) begin
              found = free_slot;
              stat_q[found] = lstm_pkg::STAT_IDLE;
              alo_q[found] = c.alo;
              ahi_q[found] = c.ahi;
              spd_q[found] = '0;
              df_q[found] = 7'h10;
              snd_q[found] = '0;
            end
            r = slot_view(found, lstm_pkg::K_SLOT, 8'd0);
          end
        end
        lstm_pkg::OP_MOVE: begin
          if (c.dn >= NSLOTS || c.sn >= NSLOTS || c.dn != c.sn || c.dn < 1) begin
            r.kind = lstm_pkg::K_NOSLOT;
          end else begin
            stat_q[c.dn] = stat_q[c.dn] | 7'h30;
            r = slot_view(c.dn, lstm_pkg::K_THR, {3'b100, df_q[c.dn][4:0]});
          end
        end
        lstm_pkg::OP_STAT: begin
          if (c.sn < NSLOTS) stat_q[c.sn] = c.val;
          has = 1'b0;
        end
        lstm_pkg::OP_SPEED, lstm_pkg::OP_DIRF, lstm_pkg::OP_SOUND: begin
          if (c.sn >= NSLOTS) begin
            has = 1'b0;
          end else if (c.op == lstm_pkg::OP_SPEED) begin
            spd_q[c.sn] = c.val;
            r = slot_view(c.sn, lstm_pkg::K_THR, {3'b100, df_q[c.sn][4:0]});
          end else if (c.op == lstm_pkg::OP_DIRF) begin
            df_q[c.sn] = c.val;
            r = slot_view(c.sn, lstm_pkg::K_THR, {3'b100, df_q[c.sn][4:0]});
          end else begin
            snd_q[c.sn] = c.val[3:0];
            r = slot_view(c.sn, lstm_pkg::K_THR, {4'hB, c.val[3:0]});
          end
        end
        lstm_pkg::OP_PROG: begin
          wr = c.pcmd[6];
          ops = c.pcmd[2];
          if (c.sn != lstm_pkg::PROG_SLOT || c.pcmd == 7'd0) begin
            has = 1'b0;
          end else if (!c.pcmd[5] || (wr && ops)) begin
            r.kind = lstm_pkg::K_NOTIMP;
            r.ack = lstm_pkg::ACK_UNSUP;
          end else if (ops) begin
            has = 1'b0;
          end else begin
            r.kind = wr ? lstm_pkg::K_CVWR : lstm_pkg::K_CVRD;
            r.cvn = {c.cvh[5:4], c.cvh[0], c.cvl} + 11'd1;
            r.cvv = {c.cvh[1], c.dlo};
            r.ack = lstm_pkg::ACK_OK;
          end
        end
        default: has = 1'b0;
      endcase
      if (has) begin
        r.pwr = pwr;
        pending.push_back(r);
      end
    endfunction

    function void check_response(response_t got);
      response_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        $display("%0t: response mismatch expected %p actual %p", $time, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  command_t cmd = '0;
  logic [2:0] resp_kind;
  logic [6:0] slot_index;
  logic [6:0] slot_status;
  logic [13:0] loco_address;
  logic [6:0] speed;
  logic [6:0] dir_func;
  logic [7:0] function_byte;
  logic [1:0] power_state;
  logic [10:0] cv_number;
  logic [7:0] cv_value;
  logic [6:0] ack_code;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  slot_table_scoreboard board = new();

  loco_slot_table_manager_core #(.NUM_SLOTS(NSLOTS)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(cmd.op), .slot_num(cmd.sn), .dest_slot(cmd.dn),
    .addr_lo(cmd.alo), .addr_hi(cmd.ahi), .value(cmd.val),
    .prog_cmd(cmd.pcmd), .cv_high(cmd.cvh), .cv_low(cmd.cvl), .data_low(cmd.dlo),
    .out_valid(out_valid), .out_ready(out_ready),
    .resp_kind(resp_kind), .slot_index(slot_index), .slot_status(slot_status),
    .loco_address(loco_address), .speed(speed), .dir_func(dir_func),
    .function_byte(function_byte), .power_state(power_state),
    .cv_number(cv_number), .cv_value(cv_value), .ack_code(ack_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_command(cmd);
      if (out_valid && out_ready) begin
        board.check_response({resp_kind, slot_index, slot_status, loco_address, speed,
                              dir_func, function_byte, power_state, cv_number,
                              cv_value, ack_code});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_command(command_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_responses();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (NSLOTS + 8) @(negedge clk);
  endtask

  function automatic command_t random_noise();
    command_t c;
    c = command_t'($bits(command_t)'({$urandom, $urandom, $urandom}));
    return c;
  endfunction

  function automatic command_t random_command();
    command_t c;
    int pick;
    c = random_noise();
    pick = $urandom_range(99);
    if (pick < 10) begin
      c.op = 4'($urandom_range(15));
    end else begin
      c.op = 4'($urandom_range(lstm_pkg::OP_PROG));
      if ($urandom_range(9) < 8) c.sn = 7'($urandom_range(NSLOTS - 1));
      if ($urandom_range(3) != 0) c.dn = c.sn;
      if ($urandom_range(2) != 0) begin
        c.alo = 7'($urandom_range(3));
        c.ahi = 7'($urandom_range(1));
      end
      if (c.op == lstm_pkg::OP_STAT && $urandom_range(1) == 0) c.val = 7'h03;
      if (c.op == lstm_pkg::OP_PROG && $urandom_range(3) != 0) c.sn = lstm_pkg::PROG_SLOT;
    end
    return c;
  endfunction

  task automatic directed_phase();
    command_t c;
    c = '0;
    c.op = lstm_pkg::OP_PWR_OFF; send_command(c);
    c.op = lstm_pkg::OP_ESTOP; send_command(c);
    c.op = lstm_pkg::OP_PWR_ON; send_command(c);
    c.op = lstm_pkg::OP_REQ; c.alo = 7'h7F; c.ahi = 7'h7F; send_command(c);
    send_command(c);
    c.alo = 7'h00; c.ahi = 7'h00; send_command(c);
    c.op = lstm_pkg::OP_MOVE; c.sn = 7'd1; c.dn = 7'd1; send_command(c);
    c.dn = 7'd2; send_command(c);
    c.sn = 7'd0; c.dn = 7'd0; send_command(c);
    c.sn = 7'h7F; c.dn = 7'h7F; send_command(c);
    c.op = lstm_pkg::OP_SPEED; c.sn = 7'd1; c.val = 7'h7F; send_command(c);
    c.op = lstm_pkg::OP_DIRF; c.val = 7'h3F; send_command(c);
    c.op = lstm_pkg::OP_SOUND; c.val = 7'h7F; send_command(c);
    c.op = lstm_pkg::OP_STAT; c.sn = 7'd2; c.val = 7'h30; send_command(c);
    c.op = lstm_pkg::OP_SPEED; c.sn = 7'h7F; send_command(c);
    c.op = lstm_pkg::OP_PROG; c.sn = lstm_pkg::PROG_SLOT; c.pcmd = 7'h00; send_command(c);
    c.pcmd = 7'h40; send_command(c);
    c.pcmd = 7'h64; send_command(c);
    c.pcmd = 7'h24; send_command(c);
    c.pcmd = 7'h60; c.cvh = 7'h7F; c.cvl = 7'h7F; c.dlo = 7'h7F; send_command(c);
    c.pcmd = 7'h20; c.cvh = 7'h00; c.cvl = 7'h00; c.dlo = 7'h00; send_command(c);
    c.sn = 7'd0; c.pcmd = 7'h60; send_command(c);
    c.op = lstm_pkg::OP_NONE; send_command(c);
    for (int i = 1; i < NSLOTS; i++) begin
      c = '0; c.op = lstm_pkg::OP_REQ; c.alo = 7'(i + 10); send_command(c);
    end
    c.alo = 7'h55; send_command(c);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 55;
    directed_phase();
    drain_responses();
    for (int n = 0; n < 900; n++) begin
      if (n == 300) begin
        send_idle_pct = 55;
        recv_idle_pct = 16;
      end
      if (n == 600) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n % 150 == 149) drain_responses();
      send_command(random_command());
    end
    drain_responses();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

`default_nettype wire
